/* hw/rtl/hafv_pkg.sv */
// shared constants, types and the arctangent step table of the heading block
// no dependencies

package hafv_pkg;

	localparam int INPUT_WIDTH_DEF     = 16;
	localparam int CORDIC_STAGES_DEF   = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 8;

	localparam int OUT_W     = 17;
	localparam int ZW        = 34;
	localparam int MQ_DEPTH  = 4;
	localparam int OQ_DEPTH  = 2;

	typedef enum logic [1:0] {
		ZS_ZERO = 2'd0,
		ZS_POS  = 2'd1,
		ZS_NEG  = 2'd2
	} zstart_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] step_angle(input int unsigned idx);
		logic [31:0] a;
		case (idx)
			0:       a = 32'h2000_0000;
			1:       a = 32'h12E4_051E;
			2:       a = 32'h09FB_385B;
			3:       a = 32'h0511_11D4;
			4:       a = 32'h028B_0D43;
			5:       a = 32'h0145_D7E1;
			6:       a = 32'h00A2_F61E;
			7:       a = 32'h0051_7C55;
			8:       a = 32'h0028_BE53;
			9:       a = 32'h0014_5F2F;
			10:      a = 32'h000A_2F98;
			11:      a = 32'h0005_17CC;
			12:      a = 32'h0002_8BE6;
			13:      a = 32'h0001_45F3;
			14:      a = 32'h0000_A2FA;
			15:      a = 32'h0000_517D;
			16:      a = 32'h0000_28BE;
			17:      a = 32'h0000_145F;
			18:      a = 32'h0000_0A30;
			19:      a = 32'h0000_0518;
			20:      a = 32'h0000_028C;
			21:      a = 32'h0000_0146;
			22:      a = 32'h0000_00A3;
			23:      a = 32'h0000_0051;
			default: a = 32'h0000_0000;
		endcase
		return a;
	endfunction

endpackage

/* hw/rtl/heading_angle_from_vector.sv */
// heading in 1/2^frac degree of a signed 2-d vector, atan2(x, -y) by cordic
// depends on hafv_pkg, hafv_fifo, hafv_front, hafv_back
//
//  channel  | handshake        | beat
//  ---------+------------------+-------------------------------
//  vector   | push / full      | x_component, y_component
//  heading  | pop / empty      | angle
//
// one vector per clock sustained while results are popped; a vector passes
// from the mid queue through an input register, the rotation pipeline of
// one stage per step and the scaling and rounding registers to the result side
// reset clears only queue pointers, queue counts and stage valid bits
// pop held low fills the result queue, freezes the pipeline, then raises full

module heading_angle_from_vector
	import hafv_pkg::*;
#(
	parameter int INPUT_WIDTH     = INPUT_WIDTH_DEF,
	parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [INPUT_WIDTH-1:0] x_component,
	input  logic signed [INPUT_WIDTH-1:0] y_component,
	input  logic                          pop,
	output logic                          empty,
	output logic signed [OUT_W-1:0]       angle
);

	localparam int UW = INPUT_WIDTH + CORDIC_STAGES + 3;
	localparam int WW = 1 + OUT_W + 2 + 2 * UW;

	logic [WW-1:0]    fw_word;
	logic [WW-1:0]    mq_word;
	logic             mq_empty;
	logic             mq_pop;
	logic             oq_full;
	logic             oq_push;
	logic [OUT_W-1:0] oq_wdata;
	logic [OUT_W-1:0] oq_rdata;

	hafv_front #(
		.INPUT_WIDTH     (INPUT_WIDTH),
		.CORDIC_STAGES   (CORDIC_STAGES),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.UW              (UW),
		.WW              (WW)
	) u_front (
		.x_component (x_component),
		.y_component (y_component),
		.word        (fw_word)
	);

	hafv_fifo #(
		.DW    (WW),
		.DEPTH (MQ_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (fw_word),
		.full   (full),
		.pop    (mq_pop),
		.rdata  (mq_word),
		.empty  (mq_empty)
	);

	hafv_back #(
		.INPUT_WIDTH     (INPUT_WIDTH),
		.CORDIC_STAGES   (CORDIC_STAGES),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.UW              (UW),
		.WW              (WW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word       (mq_word),
		.word_empty (mq_empty),
		.word_pop   (mq_pop),
		.res_full   (oq_full),
		.res_push   (oq_push),
		.res_angle  (oq_wdata)
	);

	hafv_fifo #(
		.DW    (OUT_W),
		.DEPTH (OQ_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.wdata  (oq_wdata),
		.full   (oq_full),
		.pop    (pop),
		.rdata  (oq_rdata),
		.empty  (empty)
	);

	assign angle = oq_rdata;

endmodule

/* hw/rtl/hafv_fifo.sv */
// small register queue with push/full and pop/empty sides
// depends on nothing

module hafv_fifo #(
	parameter int DW    = 8,
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [DW-1:0] mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* hw/rtl/hafv_front.sv */
// front end: sorts out axis-aligned vectors and turns backward vectors around
// depends on hafv_pkg

module hafv_front
	import hafv_pkg::*;
#(
	parameter int INPUT_WIDTH     = INPUT_WIDTH_DEF,
	parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int UW              = INPUT_WIDTH + CORDIC_STAGES + 3,
	parameter int WW              = 1 + OUT_W + 2 + 2 * UW
) (
	input  logic signed [INPUT_WIDTH-1:0] x_component,
	input  logic signed [INPUT_WIDTH-1:0] y_component,
	output logic        [WW-1:0]          word
);

	localparam logic [31:0] D90   = 32'd90 << ANGLE_FRAC_BITS;
	localparam logic [31:0] DN90  = 32'd0 - D90;
	localparam logic [31:0] D180  = 32'd180 << ANGLE_FRAC_BITS;

	logic                 x_zero;
	logic                 y_zero;
	logic                 x_neg;
	logic                 y_pos;
	logic                 special;
	logic [OUT_W-1:0]     sangle;
	zstart_t              zs;
	logic signed [UW-1:0] xe;
	logic signed [UW-1:0] ye;
	logic signed [UW-1:0] u0;
	logic signed [UW-1:0] v0;

	assign x_zero  = (x_component == '0);
	assign y_zero  = (y_component == '0);
	assign x_neg   = x_component[INPUT_WIDTH-1];
	assign y_pos   = !y_component[INPUT_WIDTH-1] && !y_zero;
	assign special = x_zero || y_zero;

	assign xe = {{(UW-INPUT_WIDTH){x_component[INPUT_WIDTH-1]}}, x_component};
	assign ye = {{(UW-INPUT_WIDTH){y_component[INPUT_WIDTH-1]}}, y_component};

	always_comb begin
		priority if (y_zero) begin
			if (x_zero) begin
				sangle = '0;
			end else if (x_neg) begin
				sangle = DN90[OUT_W-1:0];
			end else begin
				sangle = D90[OUT_W-1:0];
			end
		end else if (y_pos) begin
			sangle = D180[OUT_W-1:0];
		end else begin
			sangle = '0;
		end
	end

	// backward vectors are turned by a half turn before rotation
	always_comb begin
		if (y_pos) begin
			u0 = ye <<< CORDIC_STAGES;
			v0 = (-xe) <<< CORDIC_STAGES;
			zs = x_neg ? ZS_NEG : ZS_POS;
		end else begin
			u0 = (-ye) <<< CORDIC_STAGES;
			v0 = xe <<< CORDIC_STAGES;
			zs = ZS_ZERO;
		end
	end

	assign word = {special, sangle, zs, u0, v0};

endmodule

/* hw/rtl/hafv_back.sv */
// back end: pipelined cordic vectoring, degree scaling, rounding and clamp; axis-aligned vectors take their fixed angle
// depends on hafv_pkg

module hafv_back
	import hafv_pkg::*;
#(
	parameter int INPUT_WIDTH     = INPUT_WIDTH_DEF,
	parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int UW              = INPUT_WIDTH + CORDIC_STAGES + 3,
	parameter int WW              = 1 + OUT_W + 2 + 2 * UW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WW-1:0]    word,
	input  logic             word_empty,
	output logic             word_pop,
	input  logic             res_full,
	output logic             res_push,
	output logic [OUT_W-1:0] res_angle
);

	localparam int N    = CORDIC_STAGES;
	localparam int LAST = N + 2;
	localparam int NW   = ZW + 6;
	localparam int SH   = 29 - ANGLE_FRAC_BITS;
	localparam logic signed [ZW-1:0] Z_HALF = {{(ZW-32){1'b0}}, 32'h8000_0000};
	localparam logic signed [NW-1:0] RND    = NW'(1) <<< (SH - 1);
	localparam logic signed [NW-1:0] LIMIT  = NW'(180) <<< ANGLE_FRAC_BITS;

	logic signed [UW-1:0] u_s [0:N];
	logic signed [UW-1:0] v_s [0:N];
	logic signed [ZW-1:0] z_s [0:N];
	logic                 sp_s [0:LAST-1];
	logic [OUT_W-1:0]     sa_s [0:LAST-1];
	logic                 vld_s [0:LAST];
	logic signed [NW-1:0] num_s;
	logic [OUT_W-1:0]     res_s;

	logic                 adv;
	logic                 w_special;
	logic [OUT_W-1:0]     w_sangle;
	logic [1:0]           w_zs;
	logic signed [UW-1:0] w_u;
	logic signed [UW-1:0] w_v;
	logic signed [ZW-1:0] z_init;
	logic signed [NW-1:0] ze;
	logic signed [NW-1:0] rsum;
	logic signed [NW-1:0] rq;
	logic signed [NW-1:0] rc;

	assign adv       = !vld_s[LAST] || !res_full;
	assign word_pop  = adv && !word_empty;
	assign res_push  = vld_s[LAST] && !res_full;
	assign res_angle = res_s;

	assign {w_special, w_sangle, w_zs, w_u, w_v} = word;

	always_comb begin
		unique case (w_zs)
			ZS_POS:  z_init = Z_HALF;
			ZS_NEG:  z_init = -Z_HALF;
			default: z_init = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LAST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= !word_empty;
			for (int k = 1; k <= LAST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s[0]  <= w_u;
			v_s[0]  <= w_v;
			z_s[0]  <= z_init;
			sp_s[0] <= w_special;
			sa_s[0] <= w_sangle;
			for (int k = 1; k < LAST; k++) begin
				sp_s[k] <= sp_s[k-1];
				sa_s[k] <= sa_s[k-1];
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic signed [ZW-1:0] STEP = {{(ZW-32){1'b0}}, step_angle(i)};
		logic signed [UW-1:0] du;
		logic signed [UW-1:0] dv;

		assign du = v_s[i] >>> i;
		assign dv = u_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!v_s[i][UW-1]) begin
					u_s[i+1] <= u_s[i] + du;
					v_s[i+1] <= v_s[i] - dv;
					z_s[i+1] <= z_s[i] + STEP;
				end else begin
					u_s[i+1] <= u_s[i] - du;
					v_s[i+1] <= v_s[i] + dv;
					z_s[i+1] <= z_s[i] - STEP;
				end
			end
		end
	end

	// turns to degrees: z * 45 / 2^(29 - frac), rounded half up
	assign ze   = {{(NW-ZW){z_s[N][ZW-1]}}, z_s[N]};
	assign rsum = num_s + RND;
	assign rq   = rsum >>> SH;

	always_comb begin
		priority if (rq > LIMIT) begin
			rc = LIMIT;
		end else if (rq < -LIMIT) begin
			rc = -LIMIT;
		end else begin
			rc = rq;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s <= (ze <<< 5) + (ze <<< 3) + (ze <<< 2) + ze;
			res_s <= sp_s[LAST-1] ? sa_s[LAST-1] : rc[OUT_W-1:0];
		end
	end

endmodule
